>>> sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Shared request codes, character constants, queue entry type and the
// character filter used by the line editor blocks.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned DEF_LINE_DEPTH = 128;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0]  CH_BS     = 8'd8;
  localparam logic [7:0]  CH_CR     = 8'd13;
  localparam logic [7:0]  CH_SPACE  = 8'd32;
  localparam logic [7:0]  CH_ZERO   = 8'd48;
  localparam logic [7:0]  CH_NINE   = 8'd57;
  localparam logic [7:0]  CH_UP_A   = 8'd65;
  localparam logic [7:0]  CH_UP_Z   = 8'd90;
  localparam logic [7:0]  CH_LO_A   = 8'd97;
  localparam logic [7:0]  CH_LO_Z   = 8'd122;

  localparam logic [15:0] CURSOR_MAX = 16'hFFFF;

  localparam logic [1:0]  ERASE_STEP_SPACE = 2'd1;
  localparam logic [1:0]  ERASE_STEP_LAST  = 2'd2;

  typedef enum logic [1:0] {
    REQ_BYTE     = 2'd0,
    REQ_ACTIVATE = 2'd1,
    REQ_READ     = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_ONE   = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_e;

  typedef struct packed {
    echo_e      kind;
    logic [7:0] echo_char;
    logic [7:0] read_data;
    logic [6:0] line_length;
    logic       line_complete;
    logic       overflow_cleared;
    logic       byte_accepted;
  } qent_t;

  function automatic logic passes_filter(input logic [7:0] b);
    logic ok;
    ok = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
         ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
         ((b >= CH_ZERO) && (b <= CH_NINE)) ||
         (b == CH_CR) || (b == CH_BS) || (b == CH_SPACE);
    return ok;
  endfunction

endpackage

>>> sv/cle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cle_front.sv
// ----------------------------------------------------------------------------
// Console line editor front end
// Accepts requests, filters bytes, updates the line state and the line store,
// and hands one classified entry per request to the result queue.
// ----------------------------------------------------------------------------
module cle_front #(
  parameter int unsigned LINE_DEPTH = cle_pkg::DEF_LINE_DEPTH,
  localparam int unsigned QLW       = $clog2(cle_pkg::QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            echo_mode_i,
  input  logic [6:0]      read_index_i,
  input  logic [QLW-1:0]  q_level_i,
  output logic            push_o,
  output cle_pkg::qent_t  push_ent_o
);

  import cle_pkg::*;

  localparam int unsigned AW  = $clog2(LINE_DEPTH);
  localparam int unsigned CW  = $clog2(LINE_DEPTH + 1);
  localparam int unsigned LW  = (CW > 7) ? CW : 7;

  logic [CW-1:0] wp_q, wp_d, hw_q, hw_d, wp_inc;
  logic [15:0]   cur_q, cur_d;
  logic          act_q, act_d, enter_q, enter_d, echo_q, echo_d;
  logic          s1_v_q, s1_hit_q, s1_hit_d;
  qent_t         s1_ent_q, s1_ent_d;
  logic          accept, take, is_bs, is_cr, ovf;
  logic [QLW:0]  in_flight;
  logic [LW-1:0] wp_ext, ri_ext, hw_ext;
  logic [7:0]    rdata;
  echo_e         kind;

  assign in_flight  = {1'b0, q_level_i} + (QLW + 1)'(s1_v_q);
  assign in_stall_o = in_flight >= (QLW + 1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_bs  = rx_byte_i == CH_BS;
  assign is_cr  = rx_byte_i == CH_CR;
  assign take   = accept && (req_type_i == REQ_BYTE) && act_q && !enter_q &&
                  passes_filter(rx_byte_i);
  assign wp_inc = wp_q + CW'(1);
  assign ovf    = take && !is_bs && (wp_inc == CW'(LINE_DEPTH));
  assign ri_ext = LW'(read_index_i);
  assign hw_ext = LW'(hw_q);

  always_comb begin
    wp_d    = wp_q;
    hw_d    = hw_q;
    cur_d   = cur_q;
    act_d   = act_q;
    enter_d = enter_q;
    echo_d  = echo_q;
    kind    = ECHO_NONE;
    if (accept && (req_type_i == REQ_ACTIVATE)) begin
      wp_d    = '0;
      hw_d    = '0;
      cur_d   = '0;
      act_d   = 1'b1;
      enter_d = 1'b0;
      echo_d  = echo_mode_i;
    end else if (ovf) begin
      wp_d = '0;
      hw_d = '0;
    end else if (take) begin
      if (wp_inc > hw_q) begin
        hw_d = wp_inc;
      end
      if (is_bs) begin
        wp_d = (wp_q == '0) ? '0 : wp_q - CW'(1);
      end else begin
        wp_d = wp_inc;
      end
      if (is_cr) begin
        enter_d = 1'b1;
      end
      if (echo_q) begin
        if (is_bs && (cur_q != '0)) begin
          kind  = ECHO_ERASE;
          cur_d = cur_q - 16'd1;
        end else if (!is_bs && !is_cr) begin
          kind = ECHO_ONE;
          if (cur_q != CURSOR_MAX) begin
            cur_d = cur_q + 16'd1;
          end
        end
      end
    end
  end

  assign wp_ext = LW'(wp_d);
  assign s1_hit_d = (req_type_i == REQ_READ) && (ri_ext < hw_ext);

  always_comb begin
    s1_ent_d                  = '0;
    s1_ent_d.kind             = kind;
    s1_ent_d.echo_char        = (kind == ECHO_ONE) ? rx_byte_i : 8'd0;
    s1_ent_d.line_length      = wp_ext[6:0];
    s1_ent_d.line_complete    = enter_d;
    s1_ent_d.overflow_cleared = ovf;
    s1_ent_d.byte_accepted    = take;
  end

  cle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (take),
    .waddr_i (wp_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (accept),
    .raddr_i (AW'(read_index_i)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      hw_q    <= '0;
      cur_q   <= '0;
      act_q   <= 1'b0;
      enter_q <= 1'b0;
      echo_q  <= 1'b0;
      s1_v_q  <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      hw_q    <= hw_d;
      cur_q   <= cur_d;
      act_q   <= act_d;
      enter_q <= enter_d;
      echo_q  <= echo_d;
      s1_v_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ent_q <= s1_ent_d;
      s1_hit_q <= s1_hit_d;
    end
  end

  always_comb begin
    push_ent_o           = s1_ent_q;
    push_ent_o.read_data = s1_hit_q ? rdata : 8'd0;
  end
  assign push_o = s1_v_q;

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < CW'(LINE_DEPTH))
    else $error("write position reached the store depth");

  a_fill_covers_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q >= wp_q)
    else $error("fill count below write position");

endmodule

>>> sv/cle_queue.sv
// ----------------------------------------------------------------------------
// Console line editor result queue
// Short FIFO of classified requests between the front end and the back end.
// ----------------------------------------------------------------------------
module cle_queue #(
  localparam int unsigned QLW = $clog2(cle_pkg::QUEUE_DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cle_pkg::qent_t  push_ent_i,
  input  logic            pop_i,
  output cle_pkg::qent_t  head_o,
  output logic            nonempty_o,
  output logic [QLW-1:0]  level_o
);

  import cle_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  qent_t          ent_q [QUEUE_DEPTH];
  logic [PW-1:0]  rd_q, wr_q;
  logic [QLW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QLW'(1);
        2'b01:   cnt_q <= cnt_q - QLW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_ent_i;
    end
  end

  assign head_o     = ent_q[rd_q];
  assign nonempty_o = cnt_q != '0;
  assign level_o    = cnt_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < QLW'(QUEUE_DEPTH))
    else $error("push into a full queue");

endmodule

>>> sv/cle_back.sv
// ----------------------------------------------------------------------------
// Console line editor back end
// Expands each queued request into one or three results and holds them in
// the output register until taken.
// ----------------------------------------------------------------------------
module cle_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cle_pkg::qent_t  head_i,
  input  logic            nonempty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            echo_valid_o,
  output logic [7:0]      echo_char_o,
  output logic [7:0]      read_data_o,
  output logic [6:0]      line_length_o,
  output logic            line_complete_o,
  output logic            overflow_cleared_o,
  output logic            byte_accepted_o,
  output logic            last_o
);

  import cle_pkg::*;

  logic       valid_q, valid_d, load, fin;
  logic [1:0] step_q, step_d;
  qent_t      ent_q;
  logic       ev_q, ev_d, last_q, last_d;
  logic [7:0] ec_q, ec_d;

  assign load = !valid_q || !out_stall_i;
  assign fin  = (head_i.kind != ECHO_ERASE) || (step_q == ERASE_STEP_LAST);

  always_comb begin
    valid_d = valid_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    ev_d    = head_i.kind != ECHO_NONE;
    last_d  = fin;
    unique case (head_i.kind)
      ECHO_ONE:   ec_d = head_i.echo_char;
      ECHO_ERASE: ec_d = (step_q == ERASE_STEP_SPACE) ? CH_SPACE : CH_BS;
      default:    ec_d = 8'd0;
    endcase
    if (load) begin
      valid_d = nonempty_i;
      if (nonempty_i) begin
        pop_o  = fin;
        step_d = fin ? 2'd0 : step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && nonempty_i) begin
      ent_q  <= head_i;
      ev_q   <= ev_d;
      ec_q   <= ec_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o        = valid_q;
  assign echo_valid_o       = ev_q;
  assign echo_char_o        = ec_q;
  assign read_data_o        = ent_q.read_data;
  assign line_length_o      = ent_q.line_length;
  assign line_complete_o    = ent_q.line_complete;
  assign overflow_cleared_o = ent_q.overflow_cleared;
  assign byte_accepted_o    = ent_q.byte_accepted;
  assign last_o             = last_q;

  a_only_erase_splits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> echo_valid_o && byte_accepted_o)
    else $error("non-final result without an erase echo");

  a_pop_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> nonempty_i && fin)
    else $error("queue popped before the last result");

endmodule

>>> sv/console_line_editor.sv
// ----------------------------------------------------------------------------
// Console line editor
// Results pass the front-end stage register, the result queue and the back-end
// output register. One result per cycle while the output is not stalled; a
// request gives one result, an erased character with echo gives three.
// Reset clears all control state; the line store needs no clearing pass,
// since a fill count marks which entries have been written.
// ----------------------------------------------------------------------------
module console_line_editor #(
  parameter int unsigned LINE_DEPTH = cle_pkg::DEF_LINE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] rx_byte_i,
  input  logic       echo_mode_i,
  input  logic [6:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       echo_valid_o,
  output logic [7:0] echo_char_o,
  output logic [7:0] read_data_o,
  output logic [6:0] line_length_o,
  output logic       line_complete_o,
  output logic       overflow_cleared_o,
  output logic       byte_accepted_o,
  output logic       last_o
);

  import cle_pkg::*;

  localparam int unsigned QLW = $clog2(QUEUE_DEPTH + 1);

  logic           push, pop, nonempty;
  qent_t          push_ent, head;
  logic [QLW-1:0] level;

  cle_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .echo_mode_i  (echo_mode_i),
    .read_index_i (read_index_i),
    .q_level_i    (level),
    .push_o       (push),
    .push_ent_o   (push_ent)
  );

  cle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .level_o    (level)
  );

  cle_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .nonempty_i         (nonempty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .echo_valid_o       (echo_valid_o),
    .echo_char_o        (echo_char_o),
    .read_data_o        (read_data_o),
    .line_length_o      (line_length_o),
    .line_complete_o    (line_complete_o),
    .overflow_cleared_o (overflow_cleared_o),
    .byte_accepted_o    (byte_accepted_o),
    .last_o             (last_o)
  );

endmodule
